@@ sv/assert_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// Implication whose consequent is checked at the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

@@ sv/rnm_pkg.sv @@
// Package with the constants and types of the regex NFA matcher.
package rnm_pkg;
	localparam int MAX_PATTERN = 32;
	localparam int NPOS = MAX_PATTERN + 1;
	localparam int PW = 6;
	localparam int IW = 5;

	localparam logic [7:0] CH_OPEN = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_BAR = 8'h7C;

	typedef enum logic [2:0] {
		REG_PAT0 = 3'd0,
		REG_PAT1 = 3'd1,
		REG_PAT2 = 3'd2,
		REG_PAT3 = 3'd3,
		REG_LEN = 3'd4
	} reg_idx_t;

	typedef logic [NPOS-1:0] row_t;

	typedef struct packed {
		logic busy;
		logic load;
	} cmp_status_t;

	typedef struct packed {
		logic bar;
		logic [IW-1:0] idx;
	} stk_t;
endpackage

@@ sv/rnm_compiler.sv @@
// Pattern compiler: parenthesis stack parse, then closure of the epsilon edges.
module rnm_compiler (
	input  logic clk,
	input  logic arst_n,
	input  logic restart,
	input  logic [8*rnm_pkg::MAX_PATTERN-1:0] pattern,
	input  logic [rnm_pkg::PW-1:0] plen,
	output rnm_pkg::row_t rows [rnm_pkg::NPOS],
	output logic err,
	output rnm_pkg::cmp_status_t status
);
	typedef enum logic [2:0] {ST_INIT, ST_PARSE, ST_CLOSE, ST_LOAD, ST_IDLE} state_t;

	state_t st_q;
	logic [rnm_pkg::PW-1:0] i_q, k_q, sp_q;
	rnm_pkg::stk_t stk_q [rnm_pkg::MAX_PATTERN];
	rnm_pkg::row_t cl_q [rnm_pkg::NPOS];
	logic err_q;

	logic [7:0] c, nc;
	logic [rnm_pkg::IW-1:0] inext;
	logic push, pop1, pop2, grp, star, step_err;
	logic [rnm_pkg::PW-1:0] lp, top_nx;
	rnm_pkg::stk_t top, nxt;

	// Decode the current pattern byte against the stack top.
	always_comb begin
		inext = i_q[rnm_pkg::IW-1:0] + 1'b1;
		c = pattern[{i_q[rnm_pkg::IW-1:0], 3'b000} +: 8];
		nc = pattern[{inext, 3'b000} +: 8];
		top = stk_q[0];
		nxt = stk_q[1];
		top_nx = {1'b0, top.idx} + 1'b1;
		push = 1'b0;
		pop1 = 1'b0;
		pop2 = 1'b0;
		grp = 1'b0;
		step_err = 1'b0;
		lp = i_q;
		if (c == rnm_pkg::CH_OPEN || c == rnm_pkg::CH_BAR) begin
			push = 1'b1;
		end else if (c == rnm_pkg::CH_CLOSE) begin
			if (sp_q == '0) begin
				step_err = 1'b1;
			end else if (top.bar) begin
				if (sp_q == rnm_pkg::PW'(1)) begin
					step_err = 1'b1;
					pop1 = 1'b1;
				end else begin
					pop2 = 1'b1;
					grp = 1'b1;
					lp = {1'b0, nxt.idx};
					step_err = nxt.bar;
				end
			end else begin
				pop1 = 1'b1;
				lp = {1'b0, top.idx};
			end
		end
		star = ((i_q + 1'b1) < plen) && (nc == rnm_pkg::CH_STAR);
	end

	// Sequencer, stack and edge matrix.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_INIT;
			i_q <= '0;
			k_q <= '0;
			sp_q <= '0;
			err_q <= 1'b0;
		end else if (restart) begin
			st_q <= ST_INIT;
		end else begin
			unique case (st_q)
				ST_INIT: begin
					for (int r = 0; r < rnm_pkg::NPOS; r++) begin
						cl_q[r] <= rnm_pkg::row_t'(1) << r;
					end
					i_q <= '0;
					k_q <= '0;
					sp_q <= '0;
					err_q <= 1'b0;
					st_q <= ST_PARSE;
				end
				ST_PARSE: begin
					if (i_q >= plen) begin
						if (sp_q != '0) begin
							err_q <= 1'b1;
						end
						st_q <= ST_CLOSE;
					end else begin
						if (step_err) begin
							err_q <= 1'b1;
						end
						if (push) begin
							stk_q[0] <= '{bar: (c == rnm_pkg::CH_BAR),
								idx: i_q[rnm_pkg::IW-1:0]};
							for (int j = 1; j < rnm_pkg::MAX_PATTERN; j++) begin
								stk_q[j] <= stk_q[j-1];
							end
							sp_q <= sp_q + 1'b1;
						end else if (pop1) begin
							for (int j = 0; j < rnm_pkg::MAX_PATTERN - 1; j++) begin
								stk_q[j] <= stk_q[j+1];
							end
							sp_q <= sp_q - 1'b1;
						end else if (pop2) begin
							for (int j = 0; j < rnm_pkg::MAX_PATTERN - 2; j++) begin
								stk_q[j] <= stk_q[j+2];
							end
							sp_q <= sp_q - 2'd2;
						end
						if (grp) begin
							cl_q[lp][top_nx] <= 1'b1;
							cl_q[top.idx][i_q] <= 1'b1;
						end
						if (star) begin
							cl_q[lp][i_q + 1'b1] <= 1'b1;
							cl_q[i_q + 1'b1][lp] <= 1'b1;
						end
						if (c == rnm_pkg::CH_OPEN || c == rnm_pkg::CH_STAR
								|| c == rnm_pkg::CH_CLOSE) begin
							cl_q[i_q][i_q + 1'b1] <= 1'b1;
						end
						i_q <= i_q + 1'b1;
					end
				end
				ST_CLOSE: begin
					// One pivot of the transitive closure across all rows.
					for (int r = 0; r < rnm_pkg::NPOS; r++) begin
						if (cl_q[r][k_q]) begin
							cl_q[r] <= cl_q[r] | cl_q[k_q];
						end
					end
					k_q <= k_q + 1'b1;
					if (k_q == rnm_pkg::PW'(rnm_pkg::NPOS - 1)) begin
						st_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_INIT;
				end
			endcase
		end
	end

	assign rows = cl_q;
	assign err = err_q;
	assign status.busy = (st_q != ST_IDLE);
	assign status.load = (st_q == ST_LOAD);
endmodule

@@ sv/rnm_step.sv @@
// Per-character datapath: input register, active set update, result register.
module rnm_step (
	input  logic clk,
	input  logic arst_n,
	input  rnm_pkg::cmp_status_t status,
	input  rnm_pkg::row_t rows [rnm_pkg::NPOS],
	input  logic err,
	input  logic [8*rnm_pkg::MAX_PATTERN-1:0] pattern,
	input  logic [rnm_pkg::PW-1:0] m,
	input  logic in_valid,
	output logic in_stall,
	input  logic start_req,
	input  logic has_char,
	input  logic [7:0] text_char,
	output logic out_valid,
	input  logic out_stall,
	output logic matched,
	output logic pattern_error
);
	logic valid_s1, start_s1, has_s1;
	logic [7:0] char_s1;
	rnm_pkg::row_t active_q, base, moved, nxt;
	logic adv;
	logic ovalid_s2, match_s2, err_s2;

	assign adv = valid_s1 && (!ovalid_s2 || !out_stall);
	assign in_stall = status.busy || (valid_s1 && !adv);

	// Advance matching positions and apply the closure.
	always_comb begin
		base = start_s1 ? rows[0] : active_q;
		moved = '0;
		for (int p = 0; p < rnm_pkg::MAX_PATTERN; p++) begin
			moved[p+1] = base[p] && (rnm_pkg::PW'(p) < m)
				&& (pattern[8*p +: 8] == char_s1 || pattern[8*p +: 8] == rnm_pkg::CH_DOT);
		end
		nxt = '0;
		for (int r = 0; r < rnm_pkg::NPOS; r++) begin
			if (moved[r]) begin
				nxt = nxt | rows[r];
			end
		end
		if (!has_s1) begin
			nxt = base;
		end
	end

	// Input register and active set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			active_q <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (status.load) begin
				active_q <= rows[0];
			end else if (adv) begin
				active_q <= nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			start_s1 <= start_req;
			has_s1 <= has_char;
			char_s1 <= text_char;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_s2 <= 1'b0;
		end else if (adv) begin
			ovalid_s2 <= 1'b1;
		end else if (!out_stall) begin
			ovalid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			match_s2 <= !err && nxt[m];
			err_s2 <= err;
		end
	end

	assign out_valid = ovalid_s2;
	assign matched = match_s2;
	assign pattern_error = err_s2;
endmodule

@@ sv/regex_nfa_matcher.sv @@
// out_valid rises once a character transfer has passed the input, then the result register.
// Throughput: one character per cycle while no compile or out_stall raises in_stall; the
// active-set update is one AND-OR pass over 33 rows. After reset or a register write the
// pattern compiles, one pattern byte then one closure pivot per cycle, and in_stall is
// high meanwhile. Reset clears registers to zero and starts a compile of the empty pattern.
module regex_nfa_matcher (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [5:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_stall,
	input  logic start_req,
	input  logic has_char,
	input  logic [7:0] text_char,
	output logic out_valid,
	input  logic out_stall,
	output logic matched,
	output logic pattern_error
);
	logic [63:0] pat_q [4];
	logic [rnm_pkg::PW-1:0] len_q, m;
	logic [8*rnm_pkg::MAX_PATTERN-1:0] pattern;
	logic wr, restart, err;
	rnm_pkg::reg_idx_t idx;
	rnm_pkg::row_t rows [rnm_pkg::NPOS];
	rnm_pkg::cmp_status_t status;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = rnm_pkg::reg_idx_t'(paddr[5:3]);
	assign pattern = {pat_q[3], pat_q[2], pat_q[1], pat_q[0]};
	assign m = (len_q > rnm_pkg::PW'(rnm_pkg::MAX_PATTERN))
		? rnm_pkg::PW'(rnm_pkg::MAX_PATTERN) : len_q;

	// Register read and write decode; a write to a listed register restarts compilation.
	always_comb begin
		restart = 1'b0;
		prdata = '0;
		unique case (idx)
			rnm_pkg::REG_PAT0, rnm_pkg::REG_PAT1, rnm_pkg::REG_PAT2,
			rnm_pkg::REG_PAT3: begin
				restart = wr;
				prdata = pat_q[paddr[4:3]];
			end
			rnm_pkg::REG_LEN: begin
				restart = wr;
				prdata = {58'd0, len_q};
			end
			default: begin
				restart = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 4; j++) begin
				pat_q[j] <= '0;
			end
			len_q <= '0;
		end else if (wr) begin
			if (idx == rnm_pkg::REG_LEN) begin
				len_q <= pwdata[rnm_pkg::PW-1:0];
			end else if (restart) begin
				pat_q[paddr[4:3]] <= pwdata;
			end
		end
	end

	rnm_compiler u_cmp (
		.clk(clk),
		.arst_n(arst_n),
		.restart(restart),
		.pattern(pattern),
		.plen(m),
		.rows(rows),
		.err(err),
		.status(status)
	);

	rnm_step u_step (
		.clk(clk),
		.arst_n(arst_n),
		.status(status),
		.rows(rows),
		.err(err),
		.pattern(pattern),
		.m(m),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_req(start_req),
		.has_char(has_char),
		.text_char(text_char),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.matched(matched),
		.pattern_error(pattern_error)
	);
endmodule

@@ sv/rnm_checker.sv @@
// Port-level checker for the regex NFA matcher, bound to the top level.
`include "assert_macros.svh"

module rnm_checker (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [5:0] paddr,
	input logic pready,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic matched,
	input logic pattern_error
);
	logic cfg_wr;

	// A write transfer to one of the listed registers.
	assign cfg_wr = psel && penable && pwrite && (paddr[5:3] <= rnm_pkg::REG_LEN);

	// A pattern with an error never reports a match.
	`ASSERT_IMPL(a_err_no_match, clk, arst_n, out_valid && pattern_error, !matched)
	// A register write stalls input while the pattern recompiles.
	`ASSERT_NEXT(a_wr_stalls, clk, arst_n, cfg_wr, in_stall)
	// The configuration port never inserts wait states.
	`ASSERT_IMPL(a_pready, clk, arst_n, 1'b1, pready)
	// A stalled result stays presented.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
endmodule

bind regex_nfa_matcher rnm_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.psel(psel),
	.penable(penable),
	.pwrite(pwrite),
	.paddr(paddr),
	.pready(pready),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.matched(matched),
	.pattern_error(pattern_error)
);

@@ tb/regex_nfa_matcher_test.sv @@
// Self-checking testbench for the regex NFA matcher: directed table, then random patterns and text.
module regex_nfa_matcher_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [5:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic start_req = 1'b0;
	logic has_char = 1'b0;
	logic [7:0] text_char = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic matched;
	logic pattern_error;

	regex_nfa_matcher u_top (.*);

	always #6 clk = ~clk;

	// Verdict expected for one text transfer.
	typedef struct {
		logic hit;
		logic err;
	} verdict_t;

	verdict_t verdict_q[$];

	// Shadow copy of the pattern registers and the compiled automaton.
	logic [63:0] shadow_pat[4];
	logic [5:0] shadow_len;
	rnm_pkg::row_t reach[rnm_pkg::NPOS];
	rnm_pkg::row_t live_set;
	logic nfa_err;
	int accept_pos;

	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	int patterns_loaded = 0;
	int cycles = 0;
	bit sender_idles = 1'b1;
	bit hold_request = 1'b0;

	function automatic logic [7:0] pat_char(int i);
		if (i >= 32)
			return 8'h00;
		return shadow_pat[i >> 3][(i & 7) * 8 +: 8];
	endfunction

	// Compile the pattern into epsilon edges and take their closure.
	function automatic void build_closure();
		int stk[rnm_pkg::NPOS];
		int sp;
		int m;
		int lp;
		int top;
		logic [7:0] c;
		sp = 0;
		m = shadow_len;
		if (m > rnm_pkg::MAX_PATTERN)
			m = rnm_pkg::MAX_PATTERN;
		accept_pos = m;
		nfa_err = 1'b0;
		for (int i = 0; i < rnm_pkg::NPOS; i++)
			reach[i] = '0;
		for (int i = 0; i < m; i++) begin
			c = pat_char(i);
			lp = i;
			if (c == rnm_pkg::CH_OPEN || c == rnm_pkg::CH_BAR) begin
				stk[sp] = i;
				sp++;
			end else if (c == rnm_pkg::CH_CLOSE) begin
				if (sp == 0) begin
					nfa_err = 1'b1;
				end else begin
					sp--;
					top = stk[sp];
					if (pat_char(top) == rnm_pkg::CH_BAR) begin
						if (sp == 0) begin
							nfa_err = 1'b1;
						end else begin
							sp--;
							lp = stk[sp];
							if (pat_char(lp) != rnm_pkg::CH_OPEN)
								nfa_err = 1'b1;
							reach[lp][top + 1] = 1'b1;
							reach[top][i] = 1'b1;
						end
					end else begin
						lp = top;
					end
				end
			end
			if (i + 1 < m && pat_char(i + 1) == rnm_pkg::CH_STAR) begin
				reach[lp][i + 1] = 1'b1;
				reach[i + 1][lp] = 1'b1;
			end
			if (c == rnm_pkg::CH_OPEN || c == rnm_pkg::CH_STAR || c == rnm_pkg::CH_CLOSE)
				reach[i][i + 1] = 1'b1;
		end
		if (sp != 0)
			nfa_err = 1'b1;
		for (int i = 0; i < rnm_pkg::NPOS; i++)
			reach[i][i] = 1'b1;
		for (int k = 0; k < rnm_pkg::NPOS; k++)
			for (int i = 0; i < rnm_pkg::NPOS; i++)
				if (reach[i][k])
					reach[i] = reach[i] | reach[k];
		live_set = reach[0];
	endfunction

	// Advance the active set by one transfer and return its verdict.
	function automatic verdict_t advance_text(logic s, logic h, logic [7:0] ch);
		verdict_t v;
		rnm_pkg::row_t moved;
		logic [7:0] pc;
		if (s)
			live_set = reach[0];
		if (h) begin
			moved = '0;
			for (int i = 0; i < accept_pos; i++) begin
				pc = pat_char(i);
				if (live_set[i] && (pc == ch || pc == rnm_pkg::CH_DOT))
					moved[i + 1] = 1'b1;
			end
			live_set = '0;
			for (int i = 0; i < rnm_pkg::NPOS; i++)
				if (moved[i])
					live_set = live_set | reach[i];
		end
		v.hit = !nfa_err && live_set[accept_pos];
		v.err = nfa_err;
		return v;
	endfunction

	// Two-phase register write; the register takes the value in the access cycle.
	task automatic reg_write(rnm_pkg::reg_idx_t idx, logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		if (idx == rnm_pkg::REG_LEN)
			shadow_len = val[5:0];
		else
			shadow_pat[idx] = val;
		build_closure();
	endtask

	// Hold the input quiet until every verdict has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_pattern(logic [63:0] p0, logic [63:0] p1, logic [63:0] p2,
			logic [63:0] p3, logic [5:0] len);
		drain();
		reg_write(rnm_pkg::REG_PAT0, p0);
		reg_write(rnm_pkg::REG_PAT1, p1);
		reg_write(rnm_pkg::REG_PAT2, p2);
		reg_write(rnm_pkg::REG_PAT3, p3);
		reg_write(rnm_pkg::REG_LEN, {58'd0, len});
		patterns_loaded++;
		repeat (3) @(posedge clk);
	endtask

	task automatic load_text_pattern(string p, logic [5:0] len);
		logic [63:0] w[4];
		for (int i = 0; i < 4; i++)
			w[i] = '0;
		for (int i = 0; i < p.len() && i < 32; i++)
			w[i >> 3][(i & 7) * 8 +: 8] = p[i];
		load_pattern(w[0], w[1], w[2], w[3], len);
	endtask

	// Offer one text transfer and record its verdict once accepted.
	task automatic send_text(logic s, logic h, logic [7:0] ch, bit typed, logic em, logic ee);
		int gap;
		verdict_t v;
		gap = sender_idles ? $urandom_range(0, 6) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_req <= s;
		has_char <= h;
		text_char <= ch;
		do
			@(posedge clk);
		while (in_stall);
		v = advance_text(s, h, ch);
		if (typed) begin
			v.hit = em;
			v.err = ee;
		end
		verdict_q.push_back(v);
		items_sent++;
	endtask

	// Build a random well-formed pattern over a small alphabet.
	task automatic random_pattern();
		string abc;
		string p;
		int r;
		byte x;
		byte y;
		abc = "abc";
		p = "";
		while (p.len() < 24 && $urandom_range(0, 7) != 0) begin
			r = $urandom_range(0, 5);
			x = abc[$urandom_range(0, 2)];
			y = abc[$urandom_range(0, 2)];
			case (r)
				0: p = {p, string'(x)};
				1: p = {p, "."};
				2: p = {p, string'(x), "*"};
				3: p = {p, "(", string'(x), string'(y), ")"};
				4: p = {p, "(", string'(x), "|", string'(y), ")"};
				default: p = {p, "(", string'(x), "|", string'(y), ")*"};
			endcase
		end
		load_text_pattern(p, 6'(p.len()));
	endtask

	// Directed rows: pattern slot, inputs, and a typed verdict where it is obvious.
	typedef struct {
		int slot;
		logic s;
		logic h;
		logic [7:0] ch;
		bit typed;
		logic em;
		logic ee;
	} row_spec_t;

	string slot_text[11] = '{"", "a*b", "(a|b)*c", ".x(yz)*", "(ab", "a)b", "(a|b|c)",
		"a|b", "x*x*x*x*x*x*x*x*x*x*x*x*x*x*x*x*", "", "(a)"};
	int slot_len[11] = '{0, 3, 7, 7, 3, 3, 7, 3, 63, 3, 3};

	row_spec_t rows[26] = '{
		'{0, 1'b0, 1'b0, 8'h00, 1, 1'b1, 1'b0},
		'{0, 1'b1, 1'b1, "a", 1, 1'b0, 1'b0},
		'{0, 1'b1, 1'b0, 8'h00, 1, 1'b1, 1'b0},
		'{1, 1'b1, 1'b1, "a", 0, 1'b0, 1'b0},
		'{1, 1'b0, 1'b1, "b", 0, 1'b0, 1'b0},
		'{1, 1'b1, 1'b1, "b", 0, 1'b0, 1'b0},
		'{1, 1'b0, 1'b1, "b", 0, 1'b0, 1'b0},
		'{2, 1'b1, 1'b1, "a", 0, 1'b0, 1'b0},
		'{2, 1'b0, 1'b1, "b", 0, 1'b0, 1'b0},
		'{2, 1'b0, 1'b1, "c", 0, 1'b0, 1'b0},
		'{3, 1'b1, 1'b1, 8'hFF, 0, 1'b0, 1'b0},
		'{3, 1'b0, 1'b1, "x", 0, 1'b0, 1'b0},
		'{3, 1'b0, 1'b1, "y", 0, 1'b0, 1'b0},
		'{3, 1'b0, 1'b1, "z", 0, 1'b0, 1'b0},
		'{4, 1'b1, 1'b1, "a", 1, 1'b0, 1'b1},
		'{4, 1'b0, 1'b1, "b", 1, 1'b0, 1'b1},
		'{5, 1'b1, 1'b0, 8'h00, 1, 1'b0, 1'b1},
		'{6, 1'b1, 1'b1, "a", 1, 1'b0, 1'b1},
		'{7, 1'b1, 1'b1, "a", 1, 1'b0, 1'b1},
		'{8, 1'b1, 1'b0, 8'h00, 0, 1'b0, 1'b0},
		'{8, 1'b0, 1'b1, "x", 0, 1'b0, 1'b0},
		'{8, 1'b0, 1'b1, 8'h00, 0, 1'b0, 1'b0},
		'{9, 1'b1, 1'b1, 8'hFF, 0, 1'b0, 1'b0},
		'{9, 1'b0, 1'b1, 8'hFF, 0, 1'b0, 1'b0},
		'{10, 1'b1, 1'b1, "(", 0, 1'b0, 1'b0},
		'{10, 1'b0, 1'b1, "a", 0, 1'b0, 1'b0}
	};

	// Main stimulus sequence.
	initial begin
		int slot;
		int n;
		logic h;
		logic [7:0] ch;
		for (int i = 0; i < 4; i++)
			shadow_pat[i] = '0;
		shadow_len = '0;
		build_closure();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		slot = 0;
		foreach (rows[i]) begin
			if (rows[i].slot != slot) begin
				slot = rows[i].slot;
				if (slot == 9)
					load_pattern('1, '1, '1, '1, 6'd3);
				else
					load_text_pattern(slot_text[slot], 6'(slot_len[slot]));
			end
			send_text(rows[i].s, rows[i].h, rows[i].ch, rows[i].typed, rows[i].em, rows[i].ee);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 2)
				load_pattern({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, 6'($urandom_range(0, 63)));
			else
				random_pattern();
			sender_idles = (ph % 3 != 1);
			n = 0;
			while (n < ITEMS_PER_PHASE) begin
				if (ph == 4 && n == 5)
					hold_request = 1'b1;
				h = ($urandom_range(0, 7) != 0);
				ch = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'("a" + $urandom_range(0, 2));
				send_text((n == 0) || ($urandom_range(0, 7) == 0), h, ch, 0, 1'b0, 1'b0);
				n++;
			end
		end
		sender_idles = 1'b1;
		drain();
		repeat (10) @(posedge clk);
		$display("Covered %0d text transfers over %0d pattern loads, %0d verdicts checked.",
			items_sent, patterns_loaded, results_seen);
		$display("Patterns included group errors, saturated length and all-ones bytes.");
		if (mismatches == 0 && verdict_q.size() == 0)
			$display("regex_nfa_matcher_test: clean");
		else
			$display("regex_nfa_matcher_test: errors");
		$finish;
	end

	// Result side: compare each transfer with the oldest verdict; stall at random or on a hold request.
	initial begin
		int wait_left;
		int hold_left;
		verdict_t v;
		wait_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				results_seen++;
				if (verdict_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transfer: matched=%b error=%b",
							matched, pattern_error);
				end else begin
					v = verdict_q.pop_front();
					if (matched !== v.hit || pattern_error !== v.err) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected matched=%b error=%b, got %b %b",
								v.hit, v.err, matched, pattern_error);
					end
				end
				wait_left = $urandom_range(0, 6);
				if (wait_left > 3 && $urandom_range(0, 1) == 0)
					wait_left = 0;
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 150;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (wait_left > 0) begin
				wait_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog on the total run length.
	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("regex_nfa_matcher_test: errors");
				$finish;
			end
		end
	end
endmodule
